[rtl/bce_pkg.sv]
package bce_pkg;

	// Decoded byte: two nibbles as high * 10 + low, so 0..165.
	typedef logic [7:0]  dec_t;
	// Full year, century * 100 + year, up to 16665.
	typedef logic [14:0] year_t;
	// Years since the epoch when the year is valid.
	typedef logic [13:0] diff_t;
	// Leap days, month offset and day of month, in days.
	typedef logic [12:0] part_t;
	typedef logic [3:0]  month_t;
	typedef logic [4:0]  mday_t;
	typedef logic [8:0]  yday_t;
	typedef logic [22:0] days_t;
	typedef logic [26:0] hrs_t;
	typedef logic [32:0] mins_t;
	typedef logic [38:0] secs_t;

	localparam year_t EPOCH_YEAR    = 15'd1970;
	// Leap years counted before the epoch: 1969 / 4.
	localparam part_t EPOCH_LEAPS   = 13'd492;
	localparam year_t CENTURY       = 15'd100;
	localparam dec_t  DEC_WEIGHT    = 8'd10;
	localparam days_t DAYS_PER_YEAR = 23'd365;
	localparam hrs_t  HOURS_PER_DAY = 27'd24;
	localparam month_t MONTH_MAX    = 4'd12;
	localparam month_t FEBRUARY     = 4'd2;
	localparam dec_t  DAY_MAX       = 8'd31;
	localparam dec_t  MONTH_MAX_DEC = 8'd12;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_YEAR    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	// Word handed from the calendar front end to the seconds back end.
	typedef struct packed {
		status_t status;
		days_t   prod;
		part_t   part;
		dec_t    hh;
		dec_t    mm;
		dec_t    ss;
	} front_t;

	function automatic dec_t bcd_decode(input logic [7:0] b);
		return dec_t'(b[7:4]) * DEC_WEIGHT + dec_t'(b[3:0]);
	endfunction

	function automatic yday_t days_before(input month_t month);
		yday_t d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/bce_front.sv]
module bce_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic                time_valid,
	input  logic [7:0]          century_bcd,
	input  logic [7:0]          year_bcd,
	input  logic [7:0]          month_bcd,
	input  logic [7:0]          day_bcd,
	input  logic [7:0]          hours_bcd,
	input  logic [7:0]          minutes_bcd,
	input  logic [7:0]          seconds_bcd,
	output logic                dn_valid,
	input  logic                dn_ready,
	output bce_pkg::front_t     dn_data
);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	// Stage 1: nibble decode.
	logic          tv_s1;
	bce_pkg::dec_t cen_s1, yr_s1, mon_s1, day_s1, hh_s1, mm_s1, ss_s1;

	// Stage 2: full year and error status.
	bce_pkg::year_t   year_s2;
	bce_pkg::status_t status_s2;
	bce_pkg::month_t  mon_s2;
	bce_pkg::mday_t   day_s2;
	bce_pkg::dec_t    hh_s2, mm_s2, ss_s2;
	bce_pkg::year_t   year_c;
	bce_pkg::status_t status_c;

	// Stage 3: whole years times 365 and the small day terms.
	bce_pkg::front_t  data_s3;
	bce_pkg::year_t   year_m1_c;
	bce_pkg::diff_t   diff_c;
	bce_pkg::part_t   part_c;
	logic             leap_c;

	assign en3      = !v_s3 || dn_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= up_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			tv_s1  <= time_valid;
			cen_s1 <= bce_pkg::bcd_decode(century_bcd);
			yr_s1  <= bce_pkg::bcd_decode(year_bcd);
			mon_s1 <= bce_pkg::bcd_decode(month_bcd);
			day_s1 <= bce_pkg::bcd_decode(day_bcd);
			hh_s1  <= bce_pkg::bcd_decode(hours_bcd);
			mm_s1  <= bce_pkg::bcd_decode(minutes_bcd);
			ss_s1  <= bce_pkg::bcd_decode(seconds_bcd);
		end
	end

	assign year_c = bce_pkg::year_t'(yr_s1) + bce_pkg::year_t'(cen_s1) * bce_pkg::CENTURY;

	// The first failing check decides the status.
	always_comb begin
		if (!tv_s1) begin
			status_c = bce_pkg::ST_INVALID;
		end else if (year_c < bce_pkg::EPOCH_YEAR) begin
			status_c = bce_pkg::ST_YEAR;
		end else if (mon_s1 == '0 || mon_s1 > bce_pkg::MONTH_MAX_DEC ||
		             day_s1 == '0 || day_s1 > bce_pkg::DAY_MAX) begin
			status_c = bce_pkg::ST_RANGE;
		end else begin
			status_c = bce_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			year_s2   <= year_c;
			status_s2 <= status_c;
			mon_s2    <= mon_s1[3:0];
			day_s2    <= day_s1[4:0];
			hh_s2     <= hh_s1;
			mm_s2     <= mm_s1;
			ss_s2     <= ss_s1;
		end
	end

	// The terms below only matter when the status is good; on errors they wrap freely.
	assign year_m1_c = year_s2 - bce_pkg::year_t'(1);
	assign diff_c    = bce_pkg::diff_t'(year_s2 - bce_pkg::EPOCH_YEAR);
	assign leap_c    = (mon_s2 > bce_pkg::FEBRUARY) && (year_s2[1:0] == 2'b00);
	assign part_c    = year_m1_c[14:2] - bce_pkg::EPOCH_LEAPS
	                 + bce_pkg::part_t'(bce_pkg::days_before(mon_s2))
	                 + bce_pkg::part_t'(leap_c)
	                 + bce_pkg::part_t'(day_s2) - bce_pkg::part_t'(1);

	always_ff @(posedge clk) begin
		if (en3) begin
			data_s3.status <= status_s2;
			data_s3.prod   <= bce_pkg::days_t'(diff_c) * bce_pkg::DAYS_PER_YEAR;
			data_s3.part   <= part_c;
			data_s3.hh     <= hh_s2;
			data_s3.mm     <= mm_s2;
			data_s3.ss     <= ss_s2;
		end
	end

	assign dn_valid = v_s3;
	assign dn_data  = data_s3;

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> (v_s1 && v_s2 && v_s3))
		else $error("front end stalls upstream with a free stage");

	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && status_s2 == bce_pkg::ST_OK) |->
		(year_s2 >= bce_pkg::EPOCH_YEAR && mon_s2 != '0 && mon_s2 <= bce_pkg::MONTH_MAX))
		else $error("good status with year or month out of range");

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !dn_ready) |=> (v_s3 && $stable(data_s3)))
		else $error("front end word changed while held");

endmodule

[rtl/bce_secs.sv]
module bce_secs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  bce_pkg::front_t     up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output logic [38:0]         epoch_seconds,
	output logic [1:0]          status
);

	logic en4, en5, en6, en7;
	logic v_s4, v_s5, v_s6, v_s7;

	bce_pkg::days_t   days_s4;
	bce_pkg::hrs_t    hrs_s5;
	bce_pkg::mins_t   mins_s6;
	bce_pkg::secs_t   secs_s7;
	bce_pkg::status_t status_s4, status_s5, status_s6, status_s7;
	bce_pkg::dec_t    hh_s4, mm_s4, mm_s5, ss_s4, ss_s5, ss_s6;
	bce_pkg::secs_t   secs_c;

	assign en7      = !v_s7 || dn_ready;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign up_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en4) begin
				v_s4 <= up_valid;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
			if (en7) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			days_s4   <= up_data.prod + bce_pkg::days_t'(up_data.part);
			status_s4 <= up_data.status;
			hh_s4     <= up_data.hh;
			mm_s4     <= up_data.mm;
			ss_s4     <= up_data.ss;
		end
		if (en5) begin
			hrs_s5    <= bce_pkg::hrs_t'(days_s4) * bce_pkg::HOURS_PER_DAY
			           + bce_pkg::hrs_t'(hh_s4);
			status_s5 <= status_s4;
			mm_s5     <= mm_s4;
			ss_s5     <= ss_s4;
		end
		if (en6) begin
			mins_s6   <= bce_pkg::mins_t'(hrs_s5) * bce_pkg::mins_t'(60)
			           + bce_pkg::mins_t'(mm_s5);
			status_s6 <= status_s5;
			ss_s6     <= ss_s5;
		end
		if (en7) begin
			secs_s7   <= secs_c;
			status_s7 <= status_s6;
		end
	end

	// Any error forces the seconds count to zero.
	always_comb begin
		if (status_s6 == bce_pkg::ST_OK) begin
			secs_c = bce_pkg::secs_t'(mins_s6) * bce_pkg::secs_t'(60)
			       + bce_pkg::secs_t'(ss_s6);
		end else begin
			secs_c = '0;
		end
	end

	assign dn_valid      = v_s7;
	assign epoch_seconds = secs_s7;
	assign status        = status_s7;

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> (v_s4 && v_s5 && v_s6 && v_s7))
		else $error("back end stalls upstream with a free stage");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && status_s7 != bce_pkg::ST_OK) |-> (secs_s7 == '0))
		else $error("error word carries a nonzero seconds count");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && en7) |=> v_s7)
		else $error("word lost between the last two stages");

endmodule

[rtl/bcd_calendar_to_epoch_seconds.sv]
// Throughput: one word per cycle; each of the seven stages holds one word, and a stall
// on the output backs up only as far as the first empty stage.
// Reset: arst_n clears the stage valid bits at once, so the pipeline comes up empty;
// the data registers are not reset. The block keeps no state between words.
module bcd_calendar_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        time_valid,
	input  logic [7:0]  century_bcd,
	input  logic [7:0]  year_bcd,
	input  logic [7:0]  month_bcd,
	input  logic [7:0]  day_bcd,
	input  logic [7:0]  hours_bcd,
	input  logic [7:0]  minutes_bcd,
	input  logic [7:0]  seconds_bcd,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [38:0] epoch_seconds,
	output logic [1:0]  status
);

	// The front end decodes the BCD bytes (stage one), forms the full year and picks
	// the status in priority order (stage two), and then multiplies the years since
	// 1970 by 365 while summing the leap days, the month offset and the day of month
	// (stage three). Leap years are those divisible by four, with no century rule.
	// The back end adds the two day terms (stage four) and then folds in hours,
	// minutes and seconds with one small constant multiply per stage (stages five to
	// seven). The last stage zeroes the count whenever the status reports an error.
	logic            front_ready;
	logic            mid_valid;
	logic            mid_ready;
	bce_pkg::front_t mid_data;

	assign in_stall = !front_ready;

	bce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (in_valid),
		.up_ready    (front_ready),
		.time_valid  (time_valid),
		.century_bcd (century_bcd),
		.year_bcd    (year_bcd),
		.month_bcd   (month_bcd),
		.day_bcd     (day_bcd),
		.hours_bcd   (hours_bcd),
		.minutes_bcd (minutes_bcd),
		.seconds_bcd (seconds_bcd),
		.dn_valid    (mid_valid),
		.dn_ready    (mid_ready),
		.dn_data     (mid_data)
	);

	// The output stage is a register of its own, so a waiting result does not stop
	// new words from entering as long as some stage behind it is free.
	bce_secs u_secs (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (mid_valid),
		.up_ready      (mid_ready),
		.up_data       (mid_data),
		.dn_valid      (out_valid),
		.dn_ready      (!out_stall),
		.epoch_seconds (epoch_seconds),
		.status        (status)
	);

endmodule

[sim/bcd_calendar_to_epoch_seconds_test.sv]
`timescale 1ns / 1ps

// One calendar snapshot as it is offered to the block.
typedef struct {
	logic       valid_flag;
	logic [7:0] century;
	logic [7:0] year;
	logic [7:0] month;
	logic [7:0] day;
	logic [7:0] hours;
	logic [7:0] minutes;
	logic [7:0] seconds;
} calendar_t;

// Expected conversion of one snapshot.
typedef struct {
	bce_pkg::secs_t   secs;
	bce_pkg::status_t code;
} stamp_t;

class epoch_scoreboard;
	stamp_t pending_stamps[$];
	int     mismatches;
	int     results_seen;

	function new();
		mismatches = 0;
		results_seen = 0;
	endfunction

	// Nibbles are weighted 10 and 1 with no digit check, so 0xFF reads as 165.
	static function int unsigned digits(logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	// Days in the months ahead of the given one, ignoring February 29.
	static function int unsigned days_ahead_of(int unsigned month);
		int unsigned sum;
		sum = 0;
		for (int unsigned m = 1; m < month; m++) begin
			if (m == 2)
				sum += 28;
			else if (m == 4 || m == 6 || m == 9 || m == 11)
				sum += 30;
			else
				sum += 31;
		end
		return sum;
	endfunction

	static function stamp_t to_epoch(calendar_t c);
		int unsigned     full_year;
		int unsigned     month;
		int unsigned     mday;
		longint unsigned days;
		longint unsigned total;
		stamp_t          r;
		r.secs = '0;
		r.code = bce_pkg::ST_OK;
		if (!c.valid_flag) begin
			r.code = bce_pkg::ST_INVALID;
			return r;
		end
		full_year = digits(c.year) + digits(c.century) * 100;
		if (full_year < 1970) begin
			r.code = bce_pkg::ST_YEAR;
			return r;
		end
		month = digits(c.month);
		mday = digits(c.day);
		if (month < 1 || month > 12 || mday < 1 || mday > 31) begin
			r.code = bce_pkg::ST_RANGE;
			return r;
		end
		// Every fourth year is a leap year here, centuries included.
		days = longint'(full_year - 1970) * 365 + (full_year - 1) / 4 - 1969 / 4;
		days += days_ahead_of(month);
		if (month > 2 && full_year % 4 == 0)
			days += 1;
		days += mday - 1;
		total = ((days * 24 + digits(c.hours)) * 60 + digits(c.minutes)) * 60
			+ digits(c.seconds);
		r.secs = total[38:0];
		return r;
	endfunction

	function void note_input(calendar_t c);
		pending_stamps.push_back(to_epoch(c));
	endfunction

	function void fault(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	function void check_result(bce_pkg::secs_t got_secs, logic [1:0] got_code);
		stamp_t want;
		if (pending_stamps.size() == 0) begin
			fault($sformatf("result %0d with nothing outstanding: secs %0d status %0d",
				results_seen, got_secs, got_code));
		end else begin
			want = pending_stamps.pop_front();
			if (got_secs !== want.secs)
				fault($sformatf("result %0d: secs %0d, expected %0d",
					results_seen, got_secs, want.secs));
			if (got_code !== want.code)
				fault($sformatf("result %0d: status %0d, expected %0d",
					results_seen, got_code, want.code));
		end
		results_seen++;
	endfunction
endclass

module bcd_calendar_to_epoch_seconds_test;

	localparam int RANDOM_WORDS = 1300;
	// The receiver's long hold-off, long enough to fill all seven stages.
	localparam int LONG_HOLD    = 100;
	// Cycles to wait once the last result is in, well past the pipeline depth.
	localparam int SETTLE       = 30;
	// Several times the slowest legal run with the longest gaps and stalls.
	localparam int WATCHDOG_NS  = 5_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        time_valid = 1'b0;
	logic [7:0]  century_bcd = '0;
	logic [7:0]  year_bcd = '0;
	logic [7:0]  month_bcd = '0;
	logic [7:0]  day_bcd = '0;
	logic [7:0]  hours_bcd = '0;
	logic [7:0]  minutes_bcd = '0;
	logic [7:0]  seconds_bcd = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [38:0] epoch_seconds;
	logic [1:0]  status;

	// Raised once by the stimulus to ask the receiver for its long hold-off.
	logic        hold_ask = 1'b0;

	epoch_scoreboard sb = new();

	bcd_calendar_to_epoch_seconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.time_valid   (time_valid),
		.century_bcd  (century_bcd),
		.year_bcd     (year_bcd),
		.month_bcd    (month_bcd),
		.day_bcd      (day_bcd),
		.hours_bcd    (hours_bcd),
		.minutes_bcd  (minutes_bcd),
		.seconds_bcd  (seconds_bcd),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.epoch_seconds(epoch_seconds),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled here at the rising edge, before any of the
	// nonblocking updates of that edge land. The result is checked ahead of the
	// input note, since no word can come out on the edge that takes it in.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(epoch_seconds, status);
		if (arst_n && in_valid && !in_stall)
			sb.note_input('{time_valid, century_bcd, year_bcd, month_bcd, day_bcd,
				hours_bcd, minutes_bcd, seconds_bcd});
	end

	function automatic calendar_t calendar(logic v, logic [7:0] c, logic [7:0] y,
		logic [7:0] mo, logic [7:0] d, logic [7:0] h, logic [7:0] mi, logic [7:0] s);
		calendar_t w;
		w = '{v, c, y, mo, d, h, mi, s};
		return w;
	endfunction

	function automatic logic [7:0] to_bcd(int unsigned n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	// Mostly plausible clock readings with random content, so that most words
	// get past every check; the rest are raw bytes or readings with one field
	// broken, which exercise the error paths and all bits of every byte.
	function automatic calendar_t random_word();
		calendar_t w;
		int unsigned pick;
		int unsigned cent;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			w = calendar(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			case ($urandom_range(0, 5))
				0:       cent = 19;
				1, 2:    cent = 20;
				3:       cent = 21;
				default: cent = $urandom_range(19, 99);
			endcase
			w.valid_flag = ($urandom_range(0, 19) != 0);
			w.century = to_bcd(cent);
			w.year = to_bcd(cent == 19 ? $urandom_range(70, 99) : $urandom_range(0, 99));
			w.month = to_bcd($urandom_range(1, 12));
			w.day = to_bcd($urandom_range(1, 31));
			// Keep the days around a leap February well covered.
			if ($urandom_range(0, 9) == 0) begin
				w.month = to_bcd($urandom_range(2, 3));
				w.day = to_bcd($urandom_range(0, 1) ? 29 : 1);
			end
			w.hours = to_bcd($urandom_range(0, 23));
			w.minutes = to_bcd($urandom_range(0, 59));
			w.seconds = to_bcd($urandom_range(0, 59));
			if (pick < 30) begin
				case ($urandom_range(0, 6))
					0:       w.century = 8'($urandom);
					1:       w.year = 8'($urandom);
					2:       w.month = 8'($urandom);
					3:       w.day = 8'($urandom);
					4:       w.hours = 8'($urandom);
					5:       w.minutes = 8'($urandom);
					default: w.seconds = 8'($urandom);
				endcase
			end
		end
		return w;
	endfunction

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one word and returns on the edge that accepts it. The payload is
	// held while the block stalls, and valid stays high into the next call.
	task automatic send_word(input calendar_t w);
		in_valid <= 1'b1;
		time_valid <= w.valid_flag;
		century_bcd <= w.century;
		year_bcd <= w.year;
		month_bcd <= w.month;
		day_bcd <= w.day;
		hours_bcd <= w.hours;
		minutes_bcd <= w.minutes;
		seconds_bcd <= w.seconds;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_stamps.size() != 0);
	endtask

	task automatic send_gapped(input calendar_t w);
		pause(pick_gap());
		send_word(w);
	endtask

	task automatic send_directed();
		// A clear valid flag wins over every other error.
		send_gapped(calendar(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// The year just before the epoch, and a bad year that also has a bad month.
		send_gapped(calendar(1'b1, 8'h19, 8'h69, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// The epoch itself and the last second of its first day.
		send_gapped(calendar(1'b1, 8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h19, 8'h70, 8'h01, 8'h01, 8'h23, 8'h59, 8'h59));
		// Month and day just outside their ranges.
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h13, 8'h10, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h05, 8'h32, 8'h00, 8'h00, 8'h00));
		// Non-decimal nibbles that still decode into range: month 10, day 25.
		send_gapped(calendar(1'b1, 8'h20, 8'h10, 8'h0A, 8'h1F, 8'h00, 8'h00, 8'h00));
		// Leap day, the day after, and the same date in a common year.
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h23, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
		// A century year counts as leap under the divisible-by-four rule.
		send_gapped(calendar(1'b1, 8'h21, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h20, 8'h00, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
		// A day past the end of a short month simply counts onward.
		send_gapped(calendar(1'b1, 8'h20, 8'h21, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00));
		// The largest result: top year, last month and day, 165 in each time byte.
		send_gapped(calendar(1'b1, 8'hFF, 8'hFF, 8'h12, 8'h31, 8'hFF, 8'hFF, 8'hFF));
		send_gapped(calendar(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// Century 0x1A reads as 20, so the year is 2000.
		send_gapped(calendar(1'b1, 8'h1A, 8'h00, 8'h06, 8'h15, 8'h00, 8'h00, 8'h00));
		send_gapped(calendar(1'b1, 8'h19, 8'h9F, 8'h07, 8'h04, 8'h10, 8'h20, 8'h30));
		send_gapped(calendar(1'b1, 8'h20, 8'h30, 8'h08, 8'h08, 8'hFA, 8'hAF, 8'h0F));
		send_gapped(calendar(1'b1, 8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h08));
		send_gapped(calendar(1'b1, 8'h19, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h60));
	endtask

	// Receiver: random stalls, runs of free cycles, and one long hold-off on
	// request while the sender keeps pushing, so that the input side backs up.
	initial begin : result_drain
		int free_left;
		int stall_left;
		int hold_left;
		bit hold_done;
		bit next_stall;
		free_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				next_stall = 1'b1;
			end else begin
				if (free_left == 0 && stall_left == 0) begin
					free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
						: $urandom_range(0, 6);
					stall_left = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 3);
				end
				if (free_left > 0) begin
					free_left--;
					next_stall = 1'b0;
				end else begin
					stall_left--;
					next_stall = 1'b1;
				end
			end
			out_stall <= next_stall;
		end
	end

	initial begin : stimulus
		int burst_left;
		int calm_left;
		int gap;
		burst_left = 0;
		calm_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		send_directed();
		wait_drained();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// Once, let the pipeline run completely dry before carrying on.
			if (i == 500)
				wait_drained();
			// Once, push a gapless burst into the receiver's long hold-off.
			if (i == 800) begin
				hold_ask <= 1'b1;
				burst_left = 48;
			end
			if (calm_left == 0 && $urandom_range(0, 49) == 0)
				calm_left = $urandom_range(20, 40);
			if (burst_left > 0 || calm_left > 0) begin
				gap = 0;
				if (burst_left > 0)
					burst_left--;
				if (calm_left > 0)
					calm_left--;
			end else begin
				gap = pick_gap();
			end
			pause(gap);
			send_word(random_word());
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.pending_stamps.size() != 0)
			sb.fault($sformatf("%0d expected results never arrived",
				sb.pending_stamps.size()));
		if (sb.mismatches == 0)
			$display("bcd_calendar_to_epoch_seconds: match");
		else
			$display("bcd_calendar_to_epoch_seconds: mismatch");
		$finish;
	end

	initial begin : watchdog
		#WATCHDOG_NS;
		$display("bcd_calendar_to_epoch_seconds: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/bce_pkg.sv
rtl/bce_front.sv
rtl/bce_secs.sv
rtl/bcd_calendar_to_epoch_seconds.sv
sim/bcd_calendar_to_epoch_seconds_test.sv
